@@ rtl/u8sjis_pkg.sv @@
// Shared types and constants for the UTF-8 / Shift-JIS encoding detector.
`default_nettype none

package u8sjis_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned TDATA_W = 8;

    localparam logic [7:0] MARK_BYTE0 = 8'hEF;
    localparam logic [7:0] MARK_BYTE1 = 8'hBB;
    localparam logic [7:0] MARK_BYTE2 = 8'hBF;
    localparam logic [1:0] MARK_LEN   = 2'd3;

    localparam logic [7:0] UTF8_LEAD2_MIN = 8'hC2;
    localparam logic [7:0] UTF8_LEAD4_MAX = 8'hF4;
    localparam logic [7:0] UTF8_CONT_MASK = 8'hC0;
    localparam logic [7:0] UTF8_CONT_VAL  = 8'h80;

    localparam logic [7:0] SJIS_KANA_MIN  = 8'hA1;
    localparam logic [7:0] SJIS_KANA_MAX  = 8'hDF;
    localparam logic [7:0] SJIS_LEAD1_MIN = 8'h81;
    localparam logic [7:0] SJIS_LEAD1_MAX = 8'h9F;
    localparam logic [7:0] SJIS_LEAD2_MIN = 8'hE0;
    localparam logic [7:0] SJIS_LEAD2_MAX = 8'hEF;
    localparam logic [7:0] SJIS_TRAIL1_MIN = 8'h40;
    localparam logic [7:0] SJIS_TRAIL1_MAX = 8'h7E;
    localparam logic [7:0] SJIS_TRAIL2_MIN = 8'h80;
    localparam logic [7:0] SJIS_TRAIL2_MAX = 8'hFC;

    typedef enum logic [1:0] {
        VERDICT_UTF8    = 2'd0,
        VERDICT_SJIS    = 2'd1,
        VERDICT_UNKNOWN = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [1:0] utf8_pending;
        logic       utf8_failed;
        logic       sjis_need_trail;
        logic       sjis_failed;
        logic       sjis_pair_seen;
        logic [1:0] mark_position;
        logic       mark_matching;
    } scan_state_t;

    localparam scan_state_t SCAN_STATE_INIT = '{
        utf8_pending:    2'd0,
        utf8_failed:     1'b0,
        sjis_need_trail: 1'b0,
        sjis_failed:     1'b0,
        sjis_pair_seen:  1'b0,
        mark_position:   2'd0,
        mark_matching:   1'b1
    };

endpackage

`default_nettype wire

@@ rtl/utf8_sjis_encoding_detector_core.sv @@
// An accepted final byte passes the input register, then the result register, to m_axis_tvalid.
// One byte per cycle, unless a result item meets a stalled result; one scan-state register stage.
// A byte that is not final and not an empty-message item gives no result.
// Reset (aresetn low, synchronous) empties both registers and returns the scan state to
// no pending sequence, no failures, byte-order-mark match at position zero.
// Top level of the UTF-8 / Shift-JIS encoding detector.
`default_nettype none

module utf8_sjis_encoding_detector_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    input  wire logic [u8sjis_pkg::TDATA_W-1:0]   s_axis_tdata,  // [7:0] data_byte
    input  wire logic                             s_axis_tlast,  // last_byte
    input  wire logic                             s_axis_tuser,  // [0] empty_message
    output      logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output      logic [u8sjis_pkg::TDATA_W-1:0]   m_axis_tdata   // [1:0] verdict, [7:2] zero
);

    logic                              in_valid_reg;
    logic [u8sjis_pkg::DATA_W-1:0]     in_byte_reg;
    logic                              in_last_reg;
    logic                              in_empty_reg;
    logic                              out_valid_reg;
    u8sjis_pkg::verdict_t              out_verdict_reg;
    u8sjis_pkg::verdict_t              verdict;
    logic                              makes_result;
    logic                              consume;

    assign makes_result = in_last_reg || in_empty_reg;
    // an item with no result never waits on the output side
    assign consume = in_valid_reg && (!makes_result || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg  <= s_axis_tdata[u8sjis_pkg::DATA_W-1:0];
            in_last_reg  <= s_axis_tlast;
            in_empty_reg <= s_axis_tuser;
        end
    end

    u8sjis_track u_track (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (consume),
        .data_byte     (in_byte_reg),
        .last_byte     (in_last_reg),
        .empty_message (in_empty_reg),
        .verdict       (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (consume && makes_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && makes_result) begin
            out_verdict_reg <= verdict;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(u8sjis_pkg::TDATA_W-2){1'b0}}, out_verdict_reg};

endmodule

`default_nettype wire

@@ rtl/u8sjis_track.sv @@
// Running UTF-8 / Shift-JIS / byte-order-mark state and the per-item verdict.
`default_nettype none

module u8sjis_track (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           step,
    input  wire logic [u8sjis_pkg::DATA_W-1:0]  data_byte,
    input  wire logic                           last_byte,
    input  wire logic                           empty_message,
    output u8sjis_pkg::verdict_t                verdict
);

    u8sjis_pkg::scan_state_t state_reg;
    u8sjis_pkg::scan_state_t upd;
    u8sjis_pkg::scan_state_t state_next;
    logic [7:0] mark_want;
    logic       mark_found;
    logic       utf8_ok;
    logic       sjis_ok;

    always_comb begin
        unique case (state_reg.mark_position)
            2'd0:    mark_want = u8sjis_pkg::MARK_BYTE0;
            2'd1:    mark_want = u8sjis_pkg::MARK_BYTE1;
            default: mark_want = u8sjis_pkg::MARK_BYTE2;
        endcase
    end

    always_comb begin
        upd = state_reg;

        // byte-order mark: count saturates at three
        if (state_reg.mark_matching && state_reg.mark_position != u8sjis_pkg::MARK_LEN) begin
            if (data_byte == mark_want) begin
                upd.mark_position = state_reg.mark_position + 2'd1;
            end else begin
                upd.mark_matching = 1'b0;
            end
        end

        if (!state_reg.utf8_failed) begin
            priority if (state_reg.utf8_pending != 2'd0) begin
                if ((data_byte & u8sjis_pkg::UTF8_CONT_MASK) == u8sjis_pkg::UTF8_CONT_VAL) begin
                    upd.utf8_pending = state_reg.utf8_pending - 2'd1;
                end else begin
                    upd.utf8_failed = 1'b1;
                end
            end else if (!data_byte[7]) begin
                upd.utf8_pending = 2'd0;
            end else if (data_byte[7:5] == 3'b110) begin
                if (data_byte < u8sjis_pkg::UTF8_LEAD2_MIN) begin
                    upd.utf8_failed = 1'b1;
                end else begin
                    upd.utf8_pending = 2'd1;
                end
            end else if (data_byte[7:4] == 4'b1110) begin
                upd.utf8_pending = 2'd2;
            end else if (data_byte[7:3] == 5'b11110) begin
                if (data_byte > u8sjis_pkg::UTF8_LEAD4_MAX) begin
                    upd.utf8_failed = 1'b1;
                end else begin
                    upd.utf8_pending = 2'd3;
                end
            end else begin
                upd.utf8_failed = 1'b1;
            end
        end

        if (!state_reg.sjis_failed) begin
            priority if (state_reg.sjis_need_trail) begin
                if ((data_byte >= u8sjis_pkg::SJIS_TRAIL1_MIN &&
                     data_byte <= u8sjis_pkg::SJIS_TRAIL1_MAX) ||
                    (data_byte >= u8sjis_pkg::SJIS_TRAIL2_MIN &&
                     data_byte <= u8sjis_pkg::SJIS_TRAIL2_MAX)) begin
                    upd.sjis_pair_seen  = 1'b1;
                    upd.sjis_need_trail = 1'b0;
                end else begin
                    upd.sjis_failed = 1'b1;
                end
            end else if (!data_byte[7]) begin
                upd.sjis_need_trail = 1'b0;
            end else if (data_byte >= u8sjis_pkg::SJIS_KANA_MIN &&
                         data_byte <= u8sjis_pkg::SJIS_KANA_MAX) begin
                upd.sjis_need_trail = 1'b0;
            end else if ((data_byte >= u8sjis_pkg::SJIS_LEAD1_MIN &&
                          data_byte <= u8sjis_pkg::SJIS_LEAD1_MAX) ||
                         (data_byte >= u8sjis_pkg::SJIS_LEAD2_MIN &&
                          data_byte <= u8sjis_pkg::SJIS_LEAD2_MAX)) begin
                upd.sjis_need_trail = 1'b1;
            end else begin
                upd.sjis_failed = 1'b1;
            end
        end
    end

    assign mark_found = upd.mark_matching && upd.mark_position == u8sjis_pkg::MARK_LEN;
    assign utf8_ok    = !upd.utf8_failed && upd.utf8_pending == 2'd0;
    assign sjis_ok    = !upd.sjis_failed && !upd.sjis_need_trail && upd.sjis_pair_seen;

    always_comb begin
        priority if (empty_message || mark_found || utf8_ok) begin
            verdict = u8sjis_pkg::VERDICT_UTF8;
        end else if (sjis_ok) begin
            verdict = u8sjis_pkg::VERDICT_SJIS;
        end else begin
            verdict = u8sjis_pkg::VERDICT_UNKNOWN;
        end
    end

    // message ends (or empty item): start over
    always_comb begin
        if (empty_message || last_byte) begin
            state_next = u8sjis_pkg::SCAN_STATE_INIT;
        end else begin
            state_next = upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= u8sjis_pkg::SCAN_STATE_INIT;
        end else if (step) begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/u8sjis_checker.sv @@
// Port-level assertions for the encoding detector, bound to its top level.
`default_nettype none

module u8sjis_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [u8sjis_pkg::TDATA_W-1:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_verdict_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3 && m_axis_tdata[7:2] == 6'd0))
        else $error("verdict code out of range");

    // with the output slot empty the input side never stalls
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with output slot free");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind utf8_sjis_encoding_detector_core u8sjis_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the UTF-8 / Shift-JIS encoding detector core.
module testbench;
    import u8sjis_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int TARGET_ITEMS = 1150;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_START   = 500;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } byte_item_t;

    typedef struct packed {
        bit [1:0] utf8_due;
        bit       utf8_bad;
        bit       sjis_trail_due;
        bit       sjis_bad;
        bit       sjis_pair;
        bit [1:0] bom_count;
        bit       bom_live;
    } scan_t;

    localparam scan_t SCAN_CLEAR = '{
        utf8_due: 2'd0, utf8_bad: 1'b0, sjis_trail_due: 1'b0, sjis_bad: 1'b0,
        sjis_pair: 1'b0, bom_count: 2'd0, bom_live: 1'b1
    };

    typedef enum int {
        MSG_UTF8, MSG_SJIS, MSG_BOM, MSG_NOISE, MSG_BROKEN, MSG_ABORT
    } msg_kind_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic [TDATA_W-1:0] s_axis_tdata  = '0;
    logic               s_axis_tlast  = 1'b0;
    logic               s_axis_tuser  = 1'b0;
    logic               m_axis_tready = 1'b0;
    wire                s_axis_tready;
    wire                m_axis_tvalid;
    wire [TDATA_W-1:0]  m_axis_tdata;

    byte_item_t items_pending[$];
    verdict_t   verdicts_due[$];
    logic [7:0] msg[$];

    scan_t      scan = SCAN_CLEAR;
    byte_item_t offered;
    verdict_t   due_verdict;
    int         burst_left = 1;
    int         gap_left = 0;
    int         accepted_items = 0;
    int         messages = 0;
    int         verdict_tally[3] = '{0, 0, 0};
    int         results_seen = 0;
    int         errors = 0;
    int         ready_cycles = 0;
    int         hold_left = 0;
    logic [7:0] stall_pattern = 8'hFF;
    int         idle_cycles = 0;

    utf8_sjis_encoding_detector_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
        .s_axis_tlast  (s_axis_tlast),   // last_byte
        .s_axis_tuser  (s_axis_tuser),   // [0] empty_message
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [1:0] verdict, [7:2] zero
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Runs the scanners on one accepted item; queues a verdict on a final or empty item.
    task automatic classify_item(input byte_item_t it);
        logic [7:0] b;
        logic [7:0] bom_want;
        verdict_t   v;
        b = it.data;
        v = VERDICT_UTF8;
        accepted_items++;
        if (!it.empty) begin
            if (scan.bom_live && scan.bom_count != 2'd3) begin
                bom_want = (scan.bom_count == 2'd0) ? 8'hEF :
                           (scan.bom_count == 2'd1) ? 8'hBB : 8'hBF;
                if (b == bom_want) scan.bom_count = scan.bom_count + 2'd1;
                else scan.bom_live = 1'b0;
            end

            if (!scan.utf8_bad) begin
                if (scan.utf8_due != 2'd0) begin
                    if (b[7:6] == 2'b10) scan.utf8_due = scan.utf8_due - 2'd1;
                    else scan.utf8_bad = 1'b1;
                end else if (b[7]) begin
                    if (b[7:5] == 3'b110) begin
                        if (b < 8'hC2) scan.utf8_bad = 1'b1;
                        else scan.utf8_due = 2'd1;
                    end else if (b[7:4] == 4'b1110) begin
                        scan.utf8_due = 2'd2;
                    end else if (b[7:3] == 5'b11110) begin
                        if (b > 8'hF4) scan.utf8_bad = 1'b1;
                        else scan.utf8_due = 2'd3;
                    end else begin
                        scan.utf8_bad = 1'b1;
                    end
                end
            end

            if (!scan.sjis_bad) begin
                if (scan.sjis_trail_due) begin
                    if ((b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC)) begin
                        scan.sjis_pair      = 1'b1;
                        scan.sjis_trail_due = 1'b0;
                    end else begin
                        scan.sjis_bad = 1'b1;
                    end
                end else if (b[7] && !(b >= 8'hA1 && b <= 8'hDF)) begin
                    // anything high that is not half-width kana must be a lead byte
                    if ((b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hEF))
                        scan.sjis_trail_due = 1'b1;
                    else
                        scan.sjis_bad = 1'b1;
                end
            end

            if ((scan.bom_live && scan.bom_count == 2'd3) ||
                (!scan.utf8_bad && scan.utf8_due == 2'd0))
                v = VERDICT_UTF8;
            else if (!scan.sjis_bad && !scan.sjis_trail_due && scan.sjis_pair)
                v = VERDICT_SJIS;
            else
                v = VERDICT_UNKNOWN;
        end
        if (it.empty || it.last) begin
            verdicts_due.push_back(v);
            verdict_tally[v]++;
            messages++;
            scan = SCAN_CLEAR;
        end
    endtask

    task automatic add_utf8_char();
        int n;
        n = $urandom_range(0, 3);
        case (n)
            0: msg.push_back(8'($urandom_range(8'h00, 8'h7F)));
            1: msg.push_back(8'($urandom_range(8'hC2, 8'hDF)));
            2: msg.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            default: msg.push_back(8'($urandom_range(8'hF0, 8'hF4)));
        endcase
        repeat (n) msg.push_back(8'h80 | 8'($urandom_range(0, 63)));
    endtask

    task automatic add_sjis_char();
        case ($urandom_range(0, 3))
            0: msg.push_back(8'($urandom_range(8'h00, 8'h7F)));
            1: msg.push_back(8'($urandom_range(8'hA1, 8'hDF)));
            default: begin
                if ($urandom_range(0, 1)) msg.push_back(8'($urandom_range(8'h81, 8'h9F)));
                else msg.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                if ($urandom_range(0, 1)) msg.push_back(8'($urandom_range(8'h40, 8'h7E)));
                else msg.push_back(8'($urandom_range(8'h80, 8'hFC)));
            end
        endcase
    endtask

    // Queues the collected bytes as one message; an aborted one ends in an empty-message item.
    task automatic send_message(input bit abort);
        byte_item_t it;
        foreach (msg[i]) begin
            it.data  = msg[i];
            it.last  = !abort && (i == msg.size() - 1);
            it.empty = 1'b0;
            items_pending.push_back(it);
        end
        if (abort) begin
            it.data  = 8'($urandom_range(0, 255));
            it.last  = 1'($urandom_range(0, 1));
            it.empty = 1'b1;
            items_pending.push_back(it);
        end
        msg.delete();
    endtask

    // Sender: bursts of random length with random gaps, some with no gap at all.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                classify_item(offered);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0 || items_pending.size() == 0) begin
                    if (gap_left != 0) gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    offered = items_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= offered.data;
                    s_axis_tlast  <= offered.last;
                    s_axis_tuser  <= offered.empty;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
            end
        end
    end

    // Receiver: rotating stall pattern, plus one long hold-off to back the block up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            ready_cycles++;
            if (ready_cycles == HOLD_START) hold_left = HOLD_CYCLES;
            if (ready_cycles % 64 == 0)
                stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF
                                : (8'($urandom_range(0, 255)) | 8'h01);
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= stall_pattern[ready_cycles % 8];
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (verdicts_due.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, m_axis_tdata);
                errors++;
            end else begin
                due_verdict = verdicts_due.pop_front();
                if (m_axis_tdata !== {{(TDATA_W-2){1'b0}}, due_verdict}) begin
                    $display("%0t: verdict mismatch, expected %h actual %h", $time,
                             {{(TDATA_W-2){1'b0}}, due_verdict}, m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no traffic for %0d cycles", $time, IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        msg_kind_t kind;
        int        roll;

        // directed: empty message, byte extremes, mark, truncation, pair edges
        send_message(1'b1);
        msg = '{8'h00};                      send_message(1'b0);
        msg = '{8'hFF};                      send_message(1'b0);
        msg = '{8'hEF, 8'hBB, 8'hBF, 8'hFF}; send_message(1'b0);  // mark beats failures
        msg = '{8'hEF, 8'hBB, 8'hC0};        send_message(1'b0);  // mark broken on third byte
        msg = '{8'hC3};                      send_message(1'b0);  // unfinished UTF-8
        msg = '{8'h9F, 8'h40};               send_message(1'b0);
        msg = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_message(1'b0);
        msg = '{8'hC1, 8'hA1};               send_message(1'b0);
        msg = '{8'h81};                      send_message(1'b1);  // dropped mid-message
        msg = '{8'hE0, 8'hFC};               send_message(1'b0);
        msg = '{8'h81, 8'h7F};               send_message(1'b0);
        msg = '{8'h82};                      send_message(1'b0);  // missing trail byte

        while (items_pending.size() < TARGET_ITEMS) begin
            roll = $urandom_range(0, 9);
            kind = (roll < 3) ? MSG_UTF8 : (roll < 6) ? MSG_SJIS : msg_kind_t'(roll - 4);
            case (kind)
                MSG_UTF8: begin
                    repeat ($urandom_range(1, 8)) add_utf8_char();
                    send_message(1'b0);
                end
                MSG_SJIS: begin
                    repeat ($urandom_range(1, 8)) add_sjis_char();
                    send_message(1'b0);
                end
                MSG_BOM: begin
                    msg = '{8'hEF, 8'hBB, 8'hBF};
                    if ($urandom_range(0, 2) == 0)
                        repeat ($urandom_range(1, 2)) void'(msg.pop_back());
                    repeat ($urandom_range(0, 5)) begin
                        if ($urandom_range(0, 1)) add_utf8_char();
                        else msg.push_back(8'($urandom_range(0, 255)));
                    end
                    send_message(1'b0);
                end
                MSG_NOISE: begin
                    repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom_range(0, 255)));
                    send_message(1'b0);
                end
                MSG_BROKEN: begin
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 1)) add_utf8_char();
                        else add_sjis_char();
                    end
                    if (msg.size() > 1 && $urandom_range(0, 1))
                        void'(msg.pop_back());
                    else
                        msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
                    send_message(1'b0);
                end
                default: begin
                    repeat ($urandom_range(0, 4)) begin
                        if ($urandom_range(0, 1)) add_utf8_char();
                        else add_sjis_char();
                    end
                    send_message(1'b1);
                end
            endcase
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (items_pending.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Fed %0d bytes in %0d messages: %0d UTF-8, %0d Shift-JIS, %0d unknown",
                 accepted_items, messages, verdict_tally[VERDICT_UTF8],
                 verdict_tally[VERDICT_SJIS], verdict_tally[VERDICT_UNKNOWN]);
        $display("%0d verdicts checked, %0d mismatches", results_seen, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
